/* hw/rtl/md5_stream_hasher_assert.svh */
// assertion macros shared by the md5 hasher checkers
`ifndef MD5_STREAM_HASHER_ASSERT_SVH
`define MD5_STREAM_HASHER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MD5_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MD5_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/md5_pkg.sv */
// md5 hasher package: types, round constants and round helper functions
package md5_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_CPRE,
        ST_CRND,
        ST_CADD,
        ST_EMIT
    } t_state;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] INIT_H [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate left by s
    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] w;
        w = {x, x} << s;
        return w[63:32];
    endfunction

    // rotate amount of round i
    function automatic logic [4:0] rot_amt(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word used by round i
    function automatic logic [3:0] msg_idx(input logic [5:0] i);
        logic [3:0] j;
        logic [3:0] g;
        j = i[3:0];
        case (i[5:4])
            2'd0: g = j;
            2'd1: g = j * 4'd5 + 4'd1;
            2'd2: g = j * 4'd3 + 4'd5;
            2'd3: g = j * 4'd7;
            default: g = j;
        endcase
        return g;
    endfunction

    // nonlinear function of round group grp
    function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (grp)
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (d & b) | (~d & c);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

/* hw/rtl/md5_stream_hasher.sv */
// md5 stream hasher: byte-wide message in, four digest words out
//
//   channel  | handshake                | payload
//   ---------+--------------------------+--------------------------------------
//   input    | i_in_valid / o_in_ready  | i_operation, i_data_byte
//   output   | o_out_valid / i_out_ready| o_digest_word, o_word_index, o_last_word
//
// an absorb byte is taken while idle; the 64th byte of a block starts a compression
// (a read-ahead state, 64 rounds at one round per cycle, then one chaining add)
// a finish writes padding words from the current word up to word 15 and compresses,
// again with a full padding block when the length no longer fits, then four output transfers
// the round loop reads one message word a cycle from the 16-word block memory
// reset loads the md5 initial chaining words and clears the byte count; the
// block memory needs no clearing since every byte read is written first
// input ready is low while padding, compressing or emitting; a stalled output just holds
module md5_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    // control state
    md5_pkg::t_state r_state, n_state;
    logic [63:0]     r_byte_cnt;
    logic            r_fin;      // compression belongs to a finish
    logic            r_first;    // first padding pass, marker still to place
    logic            r_extra;    // length spills into an extra block
    logic [3:0]      r_wptr;     // padding write pointer
    logic [5:0]      r_rnd;      // round counter
    logic [1:0]      r_widx;     // digest word being emitted

    // datapath
    logic [31:0] r_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d;

    // block memory, one write and one registered read port
    logic [31:0] r_blk_mem [16];
    logic [31:0] r_mdata;

    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [3:0]  mem_be;
    logic [31:0] mem_wdata;
    logic [3:0]  mem_raddr;

    logic        in_xfer;
    logic        out_xfer;
    logic [5:0]  pos;
    logic [31:0] len_lo, len_hi;
    logic [31:0] rnd_x, rnd_b;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;
    assign pos      = r_byte_cnt[5:0];

    // message length in bits, modulo 2^64
    assign len_lo = {r_byte_cnt[28:0], 3'b000};
    assign len_hi = r_byte_cnt[60:29];

    // one md5 round
    assign rnd_x = r_a + md5_pkg::round_f(r_rnd[5:4], r_b, r_c, r_d)
                 + md5_pkg::ROUND_K[r_rnd] + r_mdata;
    assign rnd_b = r_b + md5_pkg::rotl(rnd_x, md5_pkg::rot_amt(r_rnd));

    // ports
    assign o_in_ready    = (r_state == md5_pkg::ST_IDLE);
    assign o_out_valid   = (r_state == md5_pkg::ST_EMIT);
    assign o_digest_word = r_chain[r_widx];
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= md5_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and memory port control
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_wptr;
        mem_be    = 4'hf;
        mem_wdata = '0;
        mem_raddr = md5_pkg::msg_idx(r_rnd + 6'd1);
        case (r_state)
            md5_pkg::ST_IDLE: begin
                mem_waddr = pos[5:2];
                mem_be    = 4'b0001 << pos[1:0];
                mem_wdata = {4{i_data_byte}};
                if (in_xfer) begin
                    if (i_operation == md5_pkg::OP_ABSORB) begin
                        mem_we = 1'b1;
                        if (pos == 6'd63) begin
                            n_state = md5_pkg::ST_CPRE;
                        end
                    end else begin
                        n_state = md5_pkg::ST_PAD;
                    end
                end
            end
            md5_pkg::ST_PAD: begin
                mem_we = 1'b1;
                if (r_first && r_wptr == pos[5:2]) begin
                    // marker lane and zeros above it
                    mem_be    = 4'b1111 << pos[1:0];
                    mem_wdata = {24'd0, md5_pkg::PAD_MARK} << {pos[1:0], 3'b000};
                end else if (!r_extra && r_wptr == 4'd14) begin
                    mem_wdata = len_lo;
                end else if (!r_extra && r_wptr == 4'd15) begin
                    mem_wdata = len_hi;
                end
                if (r_wptr == 4'd15) begin
                    n_state = md5_pkg::ST_CPRE;
                end
            end
            md5_pkg::ST_CPRE: begin
                mem_raddr = md5_pkg::msg_idx(6'd0);
                n_state   = md5_pkg::ST_CRND;
            end
            md5_pkg::ST_CRND: begin
                if (r_rnd == 6'd63) begin
                    n_state = md5_pkg::ST_CADD;
                end
            end
            md5_pkg::ST_CADD: begin
                if (!r_fin) begin
                    n_state = md5_pkg::ST_IDLE;
                end else if (r_extra) begin
                    n_state = md5_pkg::ST_PAD;
                end else begin
                    n_state = md5_pkg::ST_EMIT;
                end
            end
            md5_pkg::ST_EMIT: begin
                if (out_xfer && r_widx == 2'd3) begin
                    n_state = md5_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = md5_pkg::ST_IDLE;
            end
        endcase
    end

    // block memory with byte-lane writes
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int k = 0; k < 4; k++) begin
                if (mem_be[k]) begin
                    r_blk_mem[mem_waddr][8*k +: 8] <= mem_wdata[8*k +: 8];
                end
            end
        end
        r_mdata <= r_blk_mem[mem_raddr];
    end

    // sequencing registers and chaining state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt <= '0;
            r_fin      <= 1'b0;
            r_first    <= 1'b0;
            r_extra    <= 1'b0;
            r_wptr     <= '0;
            r_rnd      <= '0;
            r_widx     <= '0;
            for (int k = 0; k < 4; k++) begin
                r_chain[k] <= md5_pkg::INIT_H[k];
            end
        end else begin
            case (r_state)
                md5_pkg::ST_IDLE: begin
                    if (in_xfer) begin
                        if (i_operation == md5_pkg::OP_ABSORB) begin
                            r_byte_cnt <= r_byte_cnt + 64'd1;
                            r_fin      <= 1'b0;
                        end else begin
                            // padding starts at the word holding the next byte
                            r_fin   <= 1'b1;
                            r_first <= 1'b1;
                            r_extra <= (pos[5:3] == 3'd7);
                            r_wptr  <= pos[5:2];
                        end
                    end
                end
                md5_pkg::ST_PAD: begin
                    r_wptr <= r_wptr + 4'd1;
                end
                md5_pkg::ST_CPRE: begin
                    r_rnd <= '0;
                end
                md5_pkg::ST_CRND: begin
                    r_rnd <= r_rnd + 6'd1;
                end
                md5_pkg::ST_CADD: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    if (r_fin && r_extra) begin
                        // second padding pass: zeros then the length
                        r_extra <= 1'b0;
                        r_first <= 1'b0;
                        r_wptr  <= '0;
                    end
                    r_widx <= '0;
                end
                md5_pkg::ST_EMIT: begin
                    if (out_xfer) begin
                        r_widx <= r_widx + 2'd1;
                        if (r_widx == 2'd3) begin
                            r_byte_cnt <= '0;
                            r_fin      <= 1'b0;
                            for (int k = 0; k < 4; k++) begin
                                r_chain[k] <= md5_pkg::INIT_H[k];
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // working variables, loaded before the rounds
    always_ff @(posedge i_clk) begin
        if (r_state == md5_pkg::ST_CPRE) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (r_state == md5_pkg::ST_CRND) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= rnd_b;
        end
    end

endmodule

/* hw/rtl/md5_chk.sv */
// port-level checker for the md5 hasher, bound to the top level
`include "md5_stream_hasher_assert.svh"

module md5_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_operation,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_digest_word,
    input logic [1:0]  o_word_index,
    input logic        o_last_word
);

    // a waiting digest word holds
    `MD5_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_digest_word) && $stable(o_word_index), "digest word changed while stalled")

    // no input taken while the digest goes out
    `MD5_ASSERT_NOW(a_busy_emit, i_clk, i_rst_n, o_out_valid, !o_in_ready, "input ready while emitting digest")

    // last flag marks word three only
    `MD5_ASSERT_NOW(a_last_flag, i_clk, i_rst_n, o_out_valid, o_last_word == (o_word_index == 2'd3), "last flag does not match word index")

    // digest words go out in order, back to back
    `MD5_ASSERT_NEXT(a_word_seq, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last_word, o_out_valid && o_word_index == $past(o_word_index) + 2'd1, "digest word sequence broken")

    // a finish transfer starts padding at once
    `MD5_ASSERT_NEXT(a_fin_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_operation, !o_in_ready && !o_out_valid, "block idle after finish")

endmodule

bind md5_stream_hasher md5_chk u_md5_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_operation   (i_operation),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);

/* sim/tb_top.sv */
// self-checking testbench for the md5 stream hasher: random messages against an internal md5 model
module tb_top;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } t_digest_beat;

    // tracks the running md5 state and holds the digest words still owed by the block
    class md5_scoreboard;
        logic [31:0]  chain_h [4];
        logic [31:0]  blk_w [16];
        logic [63:0]  msg_bytes;
        logic [31:0]  sine_k [64];
        int unsigned  rot_tab [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                       4, 11, 16, 23, 6, 10, 15, 21};
        t_digest_beat digest_q [$];
        int           errors;

        function new();
            real r;
            // additive constants: floor(|sin(i+1)| * 2^32)
            for (int i = 0; i < 64; i++) begin
                r = $sin(i + 1);
                if (r < 0.0) r = -r;
                sine_k[i] = 32'(longint'($floor(r * 4294967296.0)));
            end
            errors = 0;
            restart();
        endfunction

        function void restart();
            chain_h[0] = 32'h67452301;
            chain_h[1] = 32'hefcdab89;
            chain_h[2] = 32'h98badcfe;
            chain_h[3] = 32'h10325476;
            foreach (blk_w[i]) blk_w[i] = '0;
            msg_bytes = '0;
        endfunction

        function void put_byte(int unsigned pos, logic [7:0] v);
            blk_w[pos / 4][8 * (pos % 4) +: 8] = v;
        endfunction

        function void compress();
            logic [31:0] a, b, c, d, f, x, t;
            int unsigned grp, g, s;
            a = chain_h[0];
            b = chain_h[1];
            c = chain_h[2];
            d = chain_h[3];
            for (int unsigned i = 0; i < 64; i++) begin
                grp = i / 16;
                case (grp)
                    0: begin f = (b & c) | (~b & d); g = i;                end
                    1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
                    2: begin f = b ^ c ^ d;          g = (3 * i + 5) % 16; end
                    default: begin f = c ^ (b | ~d); g = (7 * i) % 16;     end
                endcase
                s = rot_tab[grp * 4 + i % 4];
                x = a + f + sine_k[i] + blk_w[g];
                t = d;
                d = c;
                c = b;
                b = b + ((x << s) | (x >> (32 - s)));
                a = t;
            end
            chain_h[0] += a;
            chain_h[1] += b;
            chain_h[2] += c;
            chain_h[3] += d;
        endfunction

        function void note_input(logic op, logic [7:0] data);
            int unsigned pos;
            logic [63:0] bits;
            t_digest_beat beat;
            pos = msg_bytes[5:0];
            if (op == md5_pkg::OP_ABSORB) begin
                put_byte(pos, data);
                msg_bytes++;
                if (pos == 63) compress();
            end else begin
                put_byte(pos, md5_pkg::PAD_MARK);
                for (int unsigned p = pos + 1; p < 64; p++) put_byte(p, 8'h00);
                // no room left for the length field: flush an extra block
                if (pos + 1 > 56) begin
                    compress();
                    foreach (blk_w[i]) blk_w[i] = '0;
                end
                bits = msg_bytes << 3;
                blk_w[14] = bits[31:0];
                blk_w[15] = bits[63:32];
                compress();
                for (int k = 0; k < 4; k++) begin
                    beat.word  = chain_h[k];
                    beat.index = 2'(k);
                    beat.last  = (k == 3);
                    digest_q.push_back(beat);
                end
                restart();
            end
        endfunction

        function void check_result(logic [31:0] word, logic [1:0] index, logic last);
            t_digest_beat exp_beat;
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest transfer word=%h index=%0d last=%0b",
                         $time, word, index, last);
                errors++;
                return;
            end
            exp_beat = digest_q.pop_front();
            if (word !== exp_beat.word) begin
                $display("%0t: digest_word mismatch expected %h actual %h",
                         $time, exp_beat.word, word);
                errors++;
            end
            if (index !== exp_beat.index) begin
                $display("%0t: word_index mismatch expected %0d actual %0d",
                         $time, exp_beat.index, index);
                errors++;
            end
            if (last !== exp_beat.last) begin
                $display("%0t: last_word mismatch expected %0b actual %0b",
                         $time, exp_beat.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_operation = md5_pkg::OP_ABSORB;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_last_word;

    md5_scoreboard sb = new();
    int unsigned   items_sent = 0;
    bit            in_calm = 1'b0;
    int unsigned   ready_hold = 0;
    int unsigned   tight_lens [10] = '{55, 56, 57, 62, 63, 64, 65, 119, 120, 128};

    md5_stream_hasher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic op, input logic [7:0] data);
        int unsigned gap;
        gap = in_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_data_byte <= data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(op, data);
        items_sent++;
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned n = 0; n < len; n++) send_item(md5_pkg::OP_ABSORB, 8'($urandom));
        send_item(md5_pkg::OP_FINISH, 8'($urandom));
    endtask

    // output side backpressure
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 9) < 3) begin
            i_out_ready <= 1'b0;
            ready_hold  <= pick_gap();
        end else begin
            i_out_ready <= 1'b1;
            ready_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                       : $urandom_range(0, 8);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_digest_word, o_word_index, o_last_word);
    end

    initial begin
        int unsigned len;
        int unsigned r;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, single extreme bytes, "abc", back-to-back finishes
        send_item(md5_pkg::OP_FINISH, 8'hff);
        send_item(md5_pkg::OP_ABSORB, 8'h00);
        send_item(md5_pkg::OP_FINISH, 8'h00);
        send_item(md5_pkg::OP_ABSORB, 8'hff);
        send_item(md5_pkg::OP_FINISH, 8'hff);
        send_item(md5_pkg::OP_ABSORB, 8'h61);
        send_item(md5_pkg::OP_ABSORB, 8'h62);
        send_item(md5_pkg::OP_ABSORB, 8'h63);
        send_item(md5_pkg::OP_FINISH, 8'h00);
        send_item(md5_pkg::OP_FINISH, 8'h55);
        send_item(md5_pkg::OP_ABSORB, 8'h80);
        send_item(md5_pkg::OP_ABSORB, 8'h7f);
        send_item(md5_pkg::OP_ABSORB, 8'h01);
        send_item(md5_pkg::OP_ABSORB, 8'hfe);
        send_item(md5_pkg::OP_FINISH, 8'haa);

        // random messages, weighted toward short ones and padding boundaries
        while (items_sent < 370) begin
            in_calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (r < 5)
                len = $urandom_range(0, 12);
            else if (r < 8)
                len = tight_lens[$urandom_range(0, 9)];
            else
                len = $urandom_range(0, 140);
            send_message(len);
        end
        i_in_valid <= 1'b0;

        while (sb.digest_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/md5_pkg.sv
hw/rtl/md5_stream_hasher.sv
hw/rtl/md5_chk.sv
sim/tb_top.sv
